@@ rtl/ec2c_pkg.sv @@
// ec2c_pkg: shared types, constants and tables for the epoch-to-calendar unit.
// Used by epoch_seconds_to_calendar_unit and ec2c_tod. No dependencies.

package ec2c_pkg;

  // Seconds within one day, 0..86399
  typedef logic [16:0] tod_t;

  // Day split: secs/128 divided by 675 (86400 = 128 * 675)
  localparam logic [22:0] DAY_RECIP  = 23'd6362914;   // floor(2^32 / 675)
  localparam logic [9:0]  DAY_DIV    = 10'd675;

  // Days counted from 1968-01-01 so that four-year cycles start on a leap year
  localparam logic [15:0] EPOCH_OFS  = 16'd731;
  localparam logic [15:0] CYC_RECIP  = 16'd45933;     // floor(2^26 / 1461)
  localparam logic [10:0] CYC_DAYS   = 11'd1461;
  localparam logic [10:0] YR1_START  = 11'd366;
  localparam logic [10:0] YR2_START  = 11'd731;
  localparam logic [10:0] YR3_START  = 11'd1096;
  localparam logic [7:0]  CYC_BASE_YEAR = 8'd68;      // 1968 - 1900

  // 2100 is not a leap year: day counts since 1970 of 2100-03-01 and 2101-01-01
  localparam logic [15:0] DAYS_2100_MAR = 16'd47541;
  localparam logic [15:0] DAYS_2101     = 16'd47847;

  // Weekday: (days + 4) mod 7, 1970-01-01 was a Thursday
  localparam logic [15:0] WDAY_OFS   = 16'd4;
  localparam logic [16:0] WDAY_RECIP = 17'd74898;     // floor(2^19 / 7)
  localparam logic [2:0]  WEEK_DAYS  = 3'd7;

  // Time of day: (tod/16) / 225 gives the hour, then sih / 60 the minute
  localparam logic [12:0] HOUR_RECIP = 13'd4660;      // floor(2^20 / 225)
  localparam logic [7:0]  HOUR_DIV   = 8'd225;
  localparam logic [12:0] MIN_RECIP  = 13'd4369;      // floor(2^18 / 60)
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;

  localparam logic [3:0]  MON_FEB    = 4'd1;

  // Zero-based day of year on which a month starts
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
    logic [8:0] base;
    case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + 9'(leap && (mon > MON_FEB));
  endfunction

endpackage

@@ rtl/ec2c_tod.sv @@
// ec2c_tod: six-stage pipeline splitting seconds-of-day into hour, minute, second.
// Depends on ec2c_pkg. All stages advance together on en.

module ec2c_tod (
  input  logic           clk,
  input  logic           en,
  input  ec2c_pkg::tod_t tod_in,
  output logic [4:0]     hour,
  output logic [5:0]     minute,
  output logic [5:0]     second
);

  // t4: hour reciprocal product
  logic [12:0] t4_x_r, t4_x_nxt;
  logic [3:0]  t4_lo_r;
  logic [25:0] t4_prod_r, t4_prod_nxt;
  // t5: hour estimate and remainder
  logic [4:0]  t5_hq_r, t5_hq_nxt;
  logic [8:0]  t5_rem_r, t5_rem_nxt;
  logic [3:0]  t5_lo_r;
  logic [12:0] t5_diff;
  // t6: corrected hour, seconds within hour
  logic [4:0]  t6_hour_r, t6_hour_nxt;
  logic [11:0] t6_sih_r, t6_sih_nxt;
  logic        t6_ge;
  logic [7:0]  t6_hr;
  // t7: minute reciprocal product
  logic [4:0]  t7_hour_r;
  logic [11:0] t7_sih_r;
  logic [24:0] t7_prod_r, t7_prod_nxt;
  // t8: minute estimate and remainder
  logic [4:0]  t8_hour_r;
  logic [5:0]  t8_mq_r, t8_mq_nxt;
  logic [6:0]  t8_rem_r, t8_rem_nxt;
  logic [11:0] t8_diff;
  // t9: outputs
  logic [4:0]  t9_hour_r;
  logic [5:0]  t9_min_r, t9_min_nxt;
  logic [5:0]  t9_sec_r, t9_sec_nxt;
  logic        t9_ge;

  always_comb begin
    t4_x_nxt    = tod_in[16:4];
    t4_prod_nxt = 26'(t4_x_nxt) * 26'(ec2c_pkg::HOUR_RECIP);

    t5_hq_nxt  = t4_prod_r[24:20];
    t5_diff    = t4_x_r - 13'(t5_hq_nxt) * 13'(ec2c_pkg::HOUR_DIV);
    t5_rem_nxt = t5_diff[8:0];

    // estimate is the true quotient or one short
    t6_ge       = t5_rem_r >= 9'(ec2c_pkg::HOUR_DIV);
    t6_hour_nxt = t5_hq_r + 5'(t6_ge);
    t6_hr       = t6_ge ? 8'(t5_rem_r - 9'(ec2c_pkg::HOUR_DIV)) : t5_rem_r[7:0];
    t6_sih_nxt  = {t6_hr, t5_lo_r};

    t7_prod_nxt = 25'(t6_sih_r) * 25'(ec2c_pkg::MIN_RECIP);

    t8_mq_nxt  = t7_prod_r[23:18];
    t8_diff    = t7_sih_r - 12'(t8_mq_nxt) * 12'(ec2c_pkg::SECS_PER_MIN);
    t8_rem_nxt = t8_diff[6:0];

    t9_ge      = t8_rem_r >= 7'(ec2c_pkg::SECS_PER_MIN);
    t9_min_nxt = t8_mq_r + 6'(t9_ge);
    t9_sec_nxt = t9_ge ? 6'(t8_rem_r - 7'(ec2c_pkg::SECS_PER_MIN)) : t8_rem_r[5:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4_x_r    <= t4_x_nxt;
      t4_lo_r   <= tod_in[3:0];
      t4_prod_r <= t4_prod_nxt;
      t5_hq_r   <= t5_hq_nxt;
      t5_rem_r  <= t5_rem_nxt;
      t5_lo_r   <= t4_lo_r;
      t6_hour_r <= t6_hour_nxt;
      t6_sih_r  <= t6_sih_nxt;
      t7_hour_r <= t6_hour_r;
      t7_sih_r  <= t6_sih_r;
      t7_prod_r <= t7_prod_nxt;
      t8_hour_r <= t7_hour_r;
      t8_mq_r   <= t8_mq_nxt;
      t8_rem_r  <= t8_rem_nxt;
      t9_hour_r <= t8_hour_r;
      t9_min_r  <= t9_min_nxt;
      t9_sec_r  <= t9_sec_nxt;
    end
  end

  assign hour   = t9_hour_r;
  assign minute = t9_min_r;
  assign second = t9_sec_r;

endmodule

@@ rtl/epoch_seconds_to_calendar_unit.sv @@
// epoch_seconds_to_calendar_unit: top level, unsigned epoch seconds to UTC calendar fields.
// Depends on ec2c_pkg and ec2c_tod.
//
// Usage:
//   Input channel in_valid / in_stall / in_epoch_seconds carries one 32-bit unsigned
//   count of seconds since 1970-01-01 00:00:00 UTC per item. Output channel
//   out_valid / out_stall carries the broken-down time: second, minute, hour,
//   weekday (0 = Sunday), year since 1900, zero-based day of year, month 0..11
//   and one-based day of month. One result item per input item, in order.
//   An item passes through the nine pipeline stages from accept to out_valid;
//   throughput is one item per cycle while the output is not stalled. Every
//   divide is a reciprocal multiply followed by a one-step correction.
//   A stall on a valid output item freezes the whole pipeline: out_stall with out_valid
//   high raises in_stall in the same cycle, nothing is dropped or repeated.
//   Bubbles are kept in place while stalled.
//   Reset (rst_n low, synchronous) clears the stage valid bits; no item is in
//   flight afterwards and out_valid is low.

module epoch_seconds_to_calendar_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_second_of_minute,
  output logic [5:0]  out_minute_of_hour,
  output logic [4:0]  out_hour_of_day,
  output logic [2:0]  out_weekday,
  output logic [7:0]  out_year_since_1900,
  output logic [8:0]  out_day_of_year,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month
);

  // Global advance: every stage moves when the output register is free or taken.
  logic       adv;
  logic [8:0] vld_r;

  assign adv      = !vld_r[8] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[7:0], in_valid};
    end
  end

  // s1: secs/128 times reciprocal of 675
  logic [47:0] s1_prod_r, s1_prod_nxt;
  logic [24:0] s1_xhi_r;
  logic [6:0]  s1_lo7_r;
  // s2: day estimate and remainder
  logic [15:0] s2_q_r, s2_q_nxt;
  logic [10:0] s2_rem_r, s2_rem_nxt;
  logic [6:0]  s2_lo7_r;
  logic [25:0] s2_diff;
  // s3: day count and seconds of day
  logic [15:0] s3_days_r, s3_days_nxt;
  ec2c_pkg::tod_t s3_tod_r, s3_tod_nxt;
  logic        s3_ge;
  logic [9:0]  s3_rem;
  // s4: four-year cycle and weekday reciprocal products
  logic [15:0] s4_n_r, s4_n_nxt;
  logic [31:0] s4_cprod_r, s4_cprod_nxt;
  logic [15:0] s4_wx_r, s4_wx_nxt;
  logic [32:0] s4_wprod_r, s4_wprod_nxt;
  logic        s4_adj_r, s4_adj_nxt;
  // s5: estimates and remainders
  logic [5:0]  s5_cq_r, s5_cq_nxt;
  logic [11:0] s5_crem_r, s5_crem_nxt;
  logic [3:0]  s5_wrem_r, s5_wrem_nxt;
  logic        s5_adj_r;
  logic [15:0] s5_cdiff;
  logic [15:0] s5_wdiff;
  // s6: year, day of year, leap flag, weekday
  logic [8:0]  s6_yday_r, s6_yday_nxt;
  logic        s6_leap_r, s6_leap_nxt;
  logic [7:0]  s6_year_r, s6_year_nxt;
  logic [2:0]  s6_wday_r, s6_wday_nxt;
  logic        s6_adj_r;
  logic        s6_cge;
  logic [5:0]  s6_cyc;
  logic [10:0] s6_r;
  logic [1:0]  s6_yic;
  logic [10:0] s6_ystart;
  // s7: month compares
  logic [10:0] s7_mask_r, s7_mask_nxt;
  logic [8:0]  s7_ydf_r;
  logic [8:0]  s7_ydo_r, s7_ydo_nxt;
  logic        s7_leap_r;
  logic [7:0]  s7_year_r;
  logic [2:0]  s7_wday_r;
  // s8: month index
  logic [3:0]  s8_mon_r, s8_mon_nxt;
  logic [8:0]  s8_ydf_r;
  logic [8:0]  s8_ydo_r;
  logic        s8_leap_r;
  logic [7:0]  s8_year_r;
  logic [2:0]  s8_wday_r;
  // s9: output register
  logic [4:0]  s9_mday_r, s9_mday_nxt;
  logic [3:0]  s9_mon_r;
  logic [8:0]  s9_ydo_r;
  logic [7:0]  s9_year_r;
  logic [2:0]  s9_wday_r;

  always_comb begin
    s1_prod_nxt = 48'(in_epoch_seconds[31:7]) * 48'(ec2c_pkg::DAY_RECIP);

    s2_q_nxt   = s1_prod_r[47:32];
    s2_diff    = 26'(s1_xhi_r) - 26'(s2_q_nxt) * 26'(ec2c_pkg::DAY_DIV);
    s2_rem_nxt = s2_diff[10:0];

    // reciprocal estimate is exact or one short
    s3_ge       = s2_rem_r >= 11'(ec2c_pkg::DAY_DIV);
    s3_days_nxt = s2_q_r + 16'(s3_ge);
    s3_rem      = s3_ge ? 10'(s2_rem_r - 11'(ec2c_pkg::DAY_DIV)) : s2_rem_r[9:0];
    s3_tod_nxt  = {s3_rem, s2_lo7_r};

    // Pretend 2100-02-29 exists: from 2100-03-01 on, shift the count by one so the
    // plain four-year cycle holds. Month/day then come out right from the leap
    // table; only the day of year within 2100 needs taking back by one.
    s4_n_nxt     = s3_days_r + ec2c_pkg::EPOCH_OFS
                 + 16'(s3_days_r >= ec2c_pkg::DAYS_2100_MAR);
    s4_cprod_nxt = 32'(s4_n_nxt) * 32'(ec2c_pkg::CYC_RECIP);
    s4_wx_nxt    = s3_days_r + ec2c_pkg::WDAY_OFS;
    s4_wprod_nxt = 33'(s4_wx_nxt) * 33'(ec2c_pkg::WDAY_RECIP);
    s4_adj_nxt   = (s3_days_r >= ec2c_pkg::DAYS_2100_MAR)
                && (s3_days_r < ec2c_pkg::DAYS_2101);

    s5_cq_nxt   = s4_cprod_r[31:26];
    s5_cdiff    = s4_n_r - 16'(s5_cq_nxt) * 16'(ec2c_pkg::CYC_DAYS);
    s5_crem_nxt = s5_cdiff[11:0];
    s5_wdiff    = s4_wx_r - 16'(s4_wprod_r[31:19]) * 16'(ec2c_pkg::WEEK_DAYS);
    s5_wrem_nxt = s5_wdiff[3:0];

    s6_cge = s5_crem_r >= 12'(ec2c_pkg::CYC_DAYS);
    s6_cyc = s5_cq_r + 6'(s6_cge);
    s6_r   = s6_cge ? 11'(s5_crem_r - 12'(ec2c_pkg::CYC_DAYS)) : s5_crem_r[10:0];
    if (s6_r < ec2c_pkg::YR1_START) begin
      s6_yic    = 2'd0;
      s6_ystart = 11'd0;
    end else if (s6_r < ec2c_pkg::YR2_START) begin
      s6_yic    = 2'd1;
      s6_ystart = ec2c_pkg::YR1_START;
    end else if (s6_r < ec2c_pkg::YR3_START) begin
      s6_yic    = 2'd2;
      s6_ystart = ec2c_pkg::YR2_START;
    end else begin
      s6_yic    = 2'd3;
      s6_ystart = ec2c_pkg::YR3_START;
    end
    s6_yday_nxt = 9'(s6_r - s6_ystart);
    s6_leap_nxt = (s6_yic == 2'd0);
    s6_year_nxt = ec2c_pkg::CYC_BASE_YEAR + 8'({s6_cyc, 2'b00}) + 8'(s6_yic);
    s6_wday_nxt = (s5_wrem_r >= 4'(ec2c_pkg::WEEK_DAYS))
                ? 3'(s5_wrem_r - 4'(ec2c_pkg::WEEK_DAYS)) : s5_wrem_r[2:0];

    // mask bit i: day lies at or past the start of month i+1
    for (int i = 0; i < 11; i++) begin
      s7_mask_nxt[i] = s6_yday_r >= ec2c_pkg::month_start(s6_leap_r, 4'(i + 1));
    end
    s7_ydo_nxt = s6_yday_r - 9'(s6_adj_r);

    s8_mon_nxt = 4'($countones(s7_mask_r));

    s9_mday_nxt = 5'(s8_ydf_r - ec2c_pkg::month_start(s8_leap_r, s8_mon_r) + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r  <= s1_prod_nxt;
      s1_xhi_r   <= in_epoch_seconds[31:7];
      s1_lo7_r   <= in_epoch_seconds[6:0];
      s2_q_r     <= s2_q_nxt;
      s2_rem_r   <= s2_rem_nxt;
      s2_lo7_r   <= s1_lo7_r;
      s3_days_r  <= s3_days_nxt;
      s3_tod_r   <= s3_tod_nxt;
      s4_n_r     <= s4_n_nxt;
      s4_cprod_r <= s4_cprod_nxt;
      s4_wx_r    <= s4_wx_nxt;
      s4_wprod_r <= s4_wprod_nxt;
      s4_adj_r   <= s4_adj_nxt;
      s5_cq_r    <= s5_cq_nxt;
      s5_crem_r  <= s5_crem_nxt;
      s5_wrem_r  <= s5_wrem_nxt;
      s5_adj_r   <= s4_adj_r;
      s6_yday_r  <= s6_yday_nxt;
      s6_leap_r  <= s6_leap_nxt;
      s6_year_r  <= s6_year_nxt;
      s6_wday_r  <= s6_wday_nxt;
      s6_adj_r   <= s5_adj_r;
      s7_mask_r  <= s7_mask_nxt;
      s7_ydf_r   <= s6_yday_r;
      s7_ydo_r   <= s7_ydo_nxt;
      s7_leap_r  <= s6_leap_r;
      s7_year_r  <= s6_year_r;
      s7_wday_r  <= s6_wday_r;
      s8_mon_r   <= s8_mon_nxt;
      s8_ydf_r   <= s7_ydf_r;
      s8_ydo_r   <= s7_ydo_r;
      s8_leap_r  <= s7_leap_r;
      s8_year_r  <= s7_year_r;
      s8_wday_r  <= s7_wday_r;
      s9_mday_r  <= s9_mday_nxt;
      s9_mon_r   <= s8_mon_r;
      s9_ydo_r   <= s8_ydo_r;
      s9_year_r  <= s8_year_r;
      s9_wday_r  <= s8_wday_r;
    end
  end

  // Time-of-day split runs alongside stages 4..9
  ec2c_tod u_tod (
    .clk    (clk),
    .en     (adv),
    .tod_in (s3_tod_r),
    .hour   (out_hour_of_day),
    .minute (out_minute_of_hour),
    .second (out_second_of_minute)
  );

  assign out_valid           = vld_r[8];
  assign out_weekday         = s9_wday_r;
  assign out_year_since_1900 = s9_year_r;
  assign out_day_of_year     = s9_ydo_r;
  assign out_month_index     = s9_mon_r;
  assign out_day_of_month    = s9_mday_r;

endmodule

@@ rtl/ec2c_chk.sv @@
// ec2c_chk: port-level checker for epoch_seconds_to_calendar_unit, bound to the top.
// No package dependency; sees the top level's ports only.

module ec2c_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] in_epoch_seconds,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_second_of_minute,
  input logic [5:0]  out_minute_of_hour,
  input logic [4:0]  out_hour_of_day,
  input logic [2:0]  out_weekday,
  input logic [7:0]  out_year_since_1900,
  input logic [8:0]  out_day_of_year,
  input logic [3:0]  out_month_index,
  input logic [4:0]  out_day_of_month
);

  // input is held off only while a finished item waits on a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled output item");

  // a waiting input item holds still until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> in_valid && $stable(in_epoch_seconds))
    else $error("stalled input item changed");

  // every delivered field is a legal calendar value
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_second_of_minute < 6'd60) && (out_minute_of_hour < 6'd60)
               && (out_hour_of_day < 5'd24) && (out_weekday < 3'd7)
               && (out_month_index < 4'd12) && (out_day_of_month != 5'd0)
               && (out_day_of_year <= 9'd365) && (out_year_since_1900 >= 8'd70)
               && (out_year_since_1900 <= 8'd206))
    else $error("output field out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output item dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_day_of_year) && $stable(out_year_since_1900)
                                && $stable(out_hour_of_day) && $stable(out_second_of_minute))
    else $error("stalled output item changed");

endmodule

bind epoch_seconds_to_calendar_unit ec2c_chk u_ec2c_chk (.*);
